// ===== design/lud_pkg.sv =====
// Package for the LU decomposer: widths and shared types.
// Used by lud_divider and lu_decomposer_top; depends on nothing.
package lud_pkg;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned IDX_W = 3;
   localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic sat;
      logic signed [WORD_W-1:0] value;
   } sat_word_type;
endpackage

// ===== design/lud_divider.sv =====
// Restoring fixed-point divider, one quotient bit per cycle.
// Depends on lud_pkg. Gives (a * 2^FRAC_BITS) / d, truncated and saturated.
module lud_divider #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [lud_pkg::WORD_W-1:0] dividend,
   input  logic signed [lud_pkg::WORD_W-1:0] divisor,
   output logic done,
   output lud_pkg::sat_word_type quotient
);
   import lud_pkg::*;

   localparam int unsigned NUM_W = WORD_W + FRAC_BITS;
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [WORD_W:0] rem_ff, rem_in;
   logic [WORD_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [WORD_W:0] trial;
   logic [WORD_W-1:0] mag_a;
   logic [NUM_W:0] qmag;
   logic signed [NUM_W+1:0] qs;

   always_comb begin
      mag_a = dividend[WORD_W-1] ? WORD_W'(-dividend) : WORD_W'(dividend);
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[WORD_W-1:0], num_ff[NUM_W-1]};
      if (start) begin
         num_in = {mag_a, {FRAC_BITS{1'b0}}};
         rem_in = '0;
         den_in = divisor[WORD_W-1] ? WORD_W'(-divisor) : WORD_W'(divisor);
         neg_in = dividend[WORD_W-1] ^ divisor[WORD_W-1];
         cnt_in = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      qmag = {1'b0, num_ff};
      qs = neg_ff ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      quotient.sat = 1'b0;
      quotient.value = qs[WORD_W-1:0];
      if (qs > $signed({{(NUM_W+2-WORD_W){1'b0}}, S32_MAX})) begin
         quotient.sat = 1'b1;
         quotient.value = S32_MAX;
      end else if (qs < $signed({{(NUM_W+2-WORD_W){1'b1}}, S32_MIN})) begin
         quotient.sat = 1'b1;
         quotient.value = S32_MIN;
      end
   end

   assign done = done_ff;
endmodule

// ===== design/lu_decomposer_top.sv =====
// LU decomposer top level: load, elimination sequencer, shared unit and output.
// Depends on lud_pkg and lud_divider.
//
// Usage: write csr_wr_en/csr_wr_data to set the order n (0 acts as 1, above
// MAX_ORDER acts as MAX_ORDER); a write drops any partly loaded matrix.
// Requests: element_value is taken when start is high and busy is low, one
// element per request in row-major order. After the last element the block
// is busy while it eliminates: each multiplier is formed in the bit-serial
// divider, and each multiply-subtract step reads two store entries,
// multiplies, subtracts and writes back, both over the one store read port.
// It then emits n*n results, marked by rsp_valid, with rsp_last_of_run on
// the final one. The receiver cannot stall; results are shown exactly once.
// Reset is synchronous: n returns to 4, the load count and singular flag
// clear. The stores are not cleared; every entry read is written first.
module lu_decomposer_top #(
   parameter int unsigned MAX_ORDER = 8,
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [lud_pkg::WORD_W-1:0] req_element_value,
   input  logic csr_wr_en,
   input  logic [3:0] csr_wr_data,
   output logic rsp_valid,
   output logic [lud_pkg::IDX_W-1:0] rsp_row_index,
   output logic [lud_pkg::IDX_W-1:0] rsp_col_index,
   output logic signed [lud_pkg::WORD_W-1:0] rsp_lower_value,
   output logic signed [lud_pkg::WORD_W-1:0] rsp_upper_value,
   output logic rsp_singular_flag,
   output logic rsp_last_of_run
);
   import lud_pkg::*;

   localparam int unsigned IW = $clog2(MAX_ORDER);
   localparam int unsigned AW = 2 * IW;
   localparam int unsigned DEPTH = 1 << AW;
   localparam int unsigned NW = IW + 1;
   localparam logic signed [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;

   typedef enum logic [3:0] {
      LOAD, PIV_RD, PIV_WAIT, COL_RD, COL_WAIT, DIV_GO, DIV_WAIT,
      UPD_RD, UPD_WAIT, UPD_MUL, UPD_SUB, LAST_RD, LAST_WAIT, OUT_RD, OUT_EMIT
   } state_type;

   state_type st_ff;
   logic [3:0] size_ff;
   logic [NW-1:0] n_eff;
   logic [IW-1:0] r_ff, c_ff, k_ff, j_ff;
   logic sing_ff;
   logic signed [WORD_W-1:0] piv_ff, m_ff, a_ff, ukj_ff;
   logic signed [2*WORD_W-1:0] prod_ff;

   logic signed [WORD_W-1:0] u_mem [DEPTH];
   logic signed [WORD_W-1:0] l_mem [DEPTH];
   logic signed [WORD_W-1:0] u_rd_ff, l_rd_ff;
   logic [AW-1:0] rd_addr;
   logic u_we;
   logic [AW-1:0] u_wa;
   logic signed [WORD_W-1:0] u_wd;
   logic l_we;
   logic signed [WORD_W-1:0] l_wd;
   logic [AW-1:0] l_wa;

   logic div_start, div_done;
   sat_word_type div_q;
   logic signed [WORD_W-1:0] pmag_v;
   logic [2*WORD_W-1:0] pabs;
   logic signed [WORD_W+1:0] diff, prod_s;
   logic p_sat;

   logic [IW-1:0] nm1;
   logic rsp_valid_ff;

   function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
      addr_of = {r, c};
   endfunction

   always_comb begin
      if (size_ff == 4'd0) n_eff = NW'(1);
      else if (32'(size_ff) > MAX_ORDER) n_eff = NW'(MAX_ORDER);
      else n_eff = NW'(size_ff);
      nm1 = IW'(n_eff - 1'b1);
   end

   lud_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(u_rd_ff), .divisor(piv_ff),
      .done(div_done), .quotient(div_q)
   );

   // Truncated product magnitude, then sign and saturation.
   always_comb begin
      pabs = prod_ff[2*WORD_W-1] ? 64'(-prod_ff) : 64'(prod_ff);
      pabs = pabs >> FRAC_BITS;
      p_sat = |pabs[2*WORD_W-1:WORD_W-1];
      prod_s = prod_ff[2*WORD_W-1] ? -$signed({2'b0, pabs[WORD_W-1:0]})
                                   : $signed({2'b0, pabs[WORD_W-1:0]});
      if (p_sat && !(prod_ff[2*WORD_W-1] && pabs == 64'h8000_0000)) begin
         prod_s = prod_ff[2*WORD_W-1] ? (WORD_W+2)'(S32_MIN) : (WORD_W+2)'(S32_MAX);
      end else if (p_sat) begin
         p_sat = 1'b0;
      end
      pmag_v = prod_s[WORD_W-1:0];
      diff = (WORD_W+2)'(a_ff) - (WORD_W+2)'(pmag_v);
   end

   // The entry below the pivot is read again in COL_WAIT, so it is on the read register when the divider is started.
   always_comb begin
      rd_addr = addr_of(r_ff, c_ff);
      unique case (st_ff)
         PIV_RD: rd_addr = addr_of(k_ff, k_ff);
         COL_RD: rd_addr = addr_of(r_ff, k_ff);
         COL_WAIT: rd_addr = addr_of(r_ff, k_ff);
         UPD_RD: rd_addr = addr_of(k_ff, j_ff);
         UPD_WAIT: rd_addr = addr_of(r_ff, j_ff);
         LAST_RD: rd_addr = addr_of(nm1, nm1);
         default: rd_addr = addr_of(r_ff, c_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      u_rd_ff <= u_mem[rd_addr];
      l_rd_ff <= l_mem[rd_addr];
      if (u_we) u_mem[u_wa] <= u_wd;
      if (l_we) l_mem[l_wa] <= l_wd;
   end

   always_comb begin
      u_we = 1'b0;
      u_wa = addr_of(r_ff, c_ff);
      u_wd = req_element_value;
      l_we = 1'b0;
      l_wa = addr_of(r_ff, k_ff);
      l_wd = div_q.value;
      div_start = 1'b0;
      unique case (st_ff)
         LOAD: u_we = start;
         DIV_GO: div_start = 1'b1;
         DIV_WAIT: l_we = div_done;
         COL_WAIT: begin
            l_we = (piv_ff == '0);
            l_wd = '0;
         end
         UPD_SUB: begin
            u_we = 1'b1;
            u_wa = addr_of(r_ff, j_ff);
            u_wd = (diff > (WORD_W+2)'(S32_MAX)) ? S32_MAX :
                   (diff < (WORD_W+2)'(S32_MIN)) ? S32_MIN : diff[WORD_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= LOAD;
         size_ff <= 4'd4;
         r_ff <= '0;
         c_ff <= '0;
         sing_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= !csr_wr_en && (st_ff == OUT_EMIT);
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
            r_ff <= '0;
            c_ff <= '0;
            sing_ff <= 1'b0;
         end else begin
            unique case (st_ff)
               LOAD: if (start) begin
                  if (c_ff == nm1) begin
                     c_ff <= '0;
                     if (r_ff == nm1) begin
                        r_ff <= '0;
                        k_ff <= '0;
                        st_ff <= PIV_RD;
                     end else r_ff <= r_ff + 1'b1;
                  end else c_ff <= c_ff + 1'b1;
               end
               PIV_RD: st_ff <= PIV_WAIT;
               PIV_WAIT: begin
                  piv_ff <= u_rd_ff;
                  if (k_ff == nm1) st_ff <= LAST_RD;
                  else begin
                     if (u_rd_ff == '0) sing_ff <= 1'b1;
                     r_ff <= k_ff + 1'b1;
                     st_ff <= COL_RD;
                  end
               end
               COL_RD: st_ff <= COL_WAIT;
               COL_WAIT: begin
                  if (piv_ff == '0) begin
                     if (r_ff == nm1) begin
                        k_ff <= k_ff + 1'b1;
                        st_ff <= PIV_RD;
                     end else begin
                        r_ff <= r_ff + 1'b1;
                        st_ff <= COL_RD;
                     end
                  end else st_ff <= DIV_GO;
               end
               DIV_GO: st_ff <= DIV_WAIT;
               DIV_WAIT: if (div_done) begin
                  m_ff <= div_q.value;
                  if (div_q.sat) sing_ff <= 1'b1;
                  j_ff <= k_ff + 1'b1;
                  st_ff <= UPD_RD;
               end
               UPD_RD: st_ff <= UPD_WAIT;
               UPD_WAIT: begin
                  ukj_ff <= u_rd_ff;
                  st_ff <= UPD_MUL;
               end
               UPD_MUL: begin
                  a_ff <= u_rd_ff;
                  prod_ff <= m_ff * ukj_ff;
                  st_ff <= UPD_SUB;
               end
               UPD_SUB: begin
                  if (p_sat || diff > (WORD_W+2)'(S32_MAX) ||
                      diff < (WORD_W+2)'(S32_MIN)) sing_ff <= 1'b1;
                  if (j_ff == nm1) begin
                     if (r_ff == nm1) begin
                        k_ff <= k_ff + 1'b1;
                        st_ff <= PIV_RD;
                     end else begin
                        r_ff <= r_ff + 1'b1;
                        st_ff <= COL_RD;
                     end
                  end else begin
                     j_ff <= j_ff + 1'b1;
                     st_ff <= UPD_RD;
                  end
               end
               LAST_RD: st_ff <= LAST_WAIT;
               LAST_WAIT: begin
                  if (u_rd_ff == '0) sing_ff <= 1'b1;
                  r_ff <= '0;
                  c_ff <= '0;
                  st_ff <= OUT_RD;
               end
               OUT_RD: st_ff <= OUT_EMIT;
               OUT_EMIT: begin
                  rsp_row_index <= IDX_W'(r_ff);
                  rsp_col_index <= IDX_W'(c_ff);
                  rsp_lower_value <= (r_ff == c_ff) ? ONE : (r_ff > c_ff) ? l_rd_ff : '0;
                  rsp_upper_value <= (r_ff > c_ff) ? '0 : u_rd_ff;
                  rsp_singular_flag <= sing_ff;
                  rsp_last_of_run <= (r_ff == nm1) && (c_ff == nm1);
                  if (c_ff == nm1) begin
                     c_ff <= '0;
                     if (r_ff == nm1) begin
                        r_ff <= '0;
                        sing_ff <= 1'b0;
                        st_ff <= LOAD;
                     end else begin
                        r_ff <= r_ff + 1'b1;
                        st_ff <= OUT_RD;
                     end
                  end else begin
                     c_ff <= c_ff + 1'b1;
                     st_ff <= OUT_RD;
                  end
               end
               default: st_ff <= LOAD;
            endcase
         end
      end
   end

   assign busy = (st_ff != LOAD);
   assign rsp_valid = rsp_valid_ff;

   a_no_rsp_when_loading: assert property (@(posedge clock) disable iff (reset)
      (st_ff == LOAD && $past(st_ff) == LOAD && !$past(reset)) |-> !rsp_valid)
      else $error("response while loading");
   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_run) |-> st_ff == LOAD)
      else $error("last response did not end run");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_done |-> st_ff == DIV_WAIT)
      else $error("divider finished outside wait");
endmodule
